[rtl/gdgc_pkg.sv]
// Shared types and constants of the drivable-ground classifier.
package gdgc_pkg;

   typedef enum logic [1:0] {
      KIND_ACCUM    = 2'd0,
      KIND_CLASSIFY = 2'd1,
      KIND_CLEAR    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSR_FORWARD_CELLS = 2'd0,
      CSR_SIDE_CELLS    = 2'd1,
      CSR_HEIGHT_SPREAD = 2'd2,
      CSR_INCLINE       = 2'd3
   } csr_index_type;

   localparam int FORWARD_W = 7;
   localparam int SIDE_W    = 6;
   localparam int SPREAD_W  = 16;
   localparam int INCLINE_W = 16;
   localparam int CSR_DW    = 16;
   localparam int CELL_NUM_W = 12;
   localparam int RSP_DW    = 16;
   localparam int IDX_W     = 17;
   localparam int MUL_W     = 32;
   localparam int FRAC_SHIFT = 24;

   localparam logic [FORWARD_W-1:0] FORWARD_RESET = 7'd30;
   localparam logic [SIDE_W-1:0]    SIDE_RESET    = 6'd15;
   localparam logic [SPREAD_W-1:0]  SPREAD_RESET  = 16'd26;
   localparam logic [INCLINE_W-1:0] INCLINE_RESET = 16'd410;

endpackage

[rtl/gdgc_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module gdgc_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/grid_drivable_ground_classifier_core.sv]
// Top level of the drivable-ground classifier: cell binning, cell store and incline test.
//
// Points are handled one at a time. An accumulate request passes from acceptance to the
// result register through index, memory read and read-modify-write of the cell entry. A
// classify request with a positive height on a flat cell also uses a single shared 32x32
// multiplier that forms the squares and then the wide incline product chunk by chunk, in
// N = ceil((2*COORD_BITS+1)/32) chunks. Other classify requests, points outside the grid
// and unused kinds skip the multiplier. A clear request sweeps all MAX_CELLS entries of the
// cell store one entry per cycle, and the same sweep runs right after reset; no request is
// taken during a sweep, while configuration writes are always taken. A new request is
// accepted while the previous result still waits in the output register.
module grid_drivable_ground_classifier_core
   import gdgc_pkg::*;
#(
   parameter int MAX_CELLS  = 4096,
   parameter int COORD_BITS = 16,
   localparam int REQ_DW = ((3 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_DW-1:0]   req_tdata,   // point_x, point_y, point_z, zero fill
   input  logic [1:0]          req_tuser,   // kind
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_DW-1:0]   rsp_tdata,   // in_grid, cell_number, cell_flat, drivable, zero fill
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [CSR_DW-1:0]   csr_data
);

   localparam int C     = COORD_BITS;
   localparam int AW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int EW    = 2 * C + 1;
   localparam int IW    = (C > 16) ? C : 16;
   localparam int SPW   = (C + 1 > SPREAD_W) ? C + 1 : SPREAD_W;
   localparam int NCH   = (2 * C + 1 + MUL_W - 1) / MUL_W;
   localparam int D2PW  = NCH * MUL_W;
   localparam int PW    = D2PW + MUL_W;
   localparam int CHW   = $clog2(NCH + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CELLS - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_INDEX,
      S_READ,
      S_MODIFY,
      S_SQX,
      S_SQY,
      S_SQZ,
      S_SQI,
      S_SUM,
      S_PROD,
      S_ACC,
      S_CMP,
      S_DONE,
      S_CLEAR
   } state_type;

   state_type                 state_ff;
   logic                      clr_rsp_ff;
   logic [AW-1:0]             clr_addr_ff;
   logic                      rsp_valid_ff;
   logic [RSP_DW-1:0]         rsp_data_ff;

   logic [FORWARD_W-1:0]      fwd_ff;
   logic [SIDE_W-1:0]         side_ff;
   logic [SPREAD_W-1:0]       spread_ff;
   logic [INCLINE_W-1:0]      incl_ff;

   kind_type                  kind_ff;
   logic [1:0]                kind_raw_ff;
   logic signed [C-1:0]       x_ff;
   logic signed [C-1:0]       y_ff;
   logic signed [C-1:0]       z_ff;
   logic [IDX_W-1:0]          idx_ff;

   logic                      res_in_ff;
   logic                      res_flat_ff;
   logic                      res_drive_ff;

   logic [2*C-1:0]            sqx_ff;
   logic [2*C-1:0]            sqy_ff;
   logic [2*C-1:0]            sqz_ff;
   logic [MUL_W-1:0]          inc2_ff;
   logic [D2PW-1:0]           d2_ff;
   logic [2*MUL_W-1:0]        prod_ff;
   logic [PW-1:0]             acc_ff;
   logic [CHW-1:0]            ch_ff;

   logic signed [IW-1:0]      cx_s;
   logic signed [IW-1:0]      cy_s;
   logic                      inside_in;
   logic [IDX_W-1:0]          idx_in;
   logic                      in_range_in;

   logic [EW-1:0]             rd_data;
   logic                      rd_used;
   logic signed [C-1:0]       rd_low;
   logic signed [C-1:0]       rd_high;
   logic signed [C-1:0]       new_low;
   logic signed [C-1:0]       new_high;
   logic                      flat_old;
   logic                      flat_new;

   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [EW-1:0]             wr_data;
   logic                      rd_en;

   logic [MUL_W-1:0]          mul_a;
   logic [MUL_W-1:0]          mul_b;
   logic [2*MUL_W-1:0]        mul_p;
   logic                      rsp_load;
   logic                      req_accept;

   function automatic logic [C-1:0] abs_coord(input logic signed [C-1:0] v);
      logic signed [C-1:0] neg;
      neg = -v;
      return v[C-1] ? C'(neg) : C'(v);
   endfunction

   function automatic logic is_flat(input logic used, input logic signed [C-1:0] high,
                                    input logic signed [C-1:0] low,
                                    input logic [SPREAD_W-1:0] limit);
      logic signed [C:0] diff;
      diff = {high[C-1], high} - {low[C-1], low};
      return used && (SPW'($unsigned(diff)) <= SPW'(limit));
   endfunction

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      cx_s = IW'(x_ff >>> 8);
      cy_s = IW'(y_ff >>> 8) + signed'(IW'(side_ff));
      inside_in = (cx_s >= 0) && (cx_s < signed'(IW'(fwd_ff))) &&
                  (cy_s >= 0) && (cy_s < signed'(IW'({side_ff, 1'b0})));
      idx_in = IDX_W'(cy_s[6:0]) * IDX_W'(fwd_ff) + IDX_W'(cx_s[6:0]);
      in_range_in = inside_in && (idx_in < IDX_W'(MAX_CELLS));
   end

   assign rd_used  = rd_data[EW-1];
   assign rd_high  = signed'(rd_data[2*C-1:C]);
   assign rd_low   = signed'(rd_data[C-1:0]);
   assign new_low  = (!rd_used || (z_ff < rd_low)) ? z_ff : rd_low;
   assign new_high = (!rd_used || (z_ff > rd_high)) ? z_ff : rd_high;
   assign flat_old = is_flat(rd_used, rd_high, rd_low, spread_ff);
   assign flat_new = is_flat(1'b1, new_high, new_low, spread_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = {1'b1, new_high, new_low};
      if (state_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else if ((state_ff == S_MODIFY) && (kind_raw_ff == KIND_ACCUM)) begin
         wr_en = 1'b1;
      end
   end

   assign rd_en = (state_ff == S_READ);

   gdgc_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      case (state_ff)
         S_SQX: begin
            mul_a = MUL_W'(abs_coord(x_ff));
            mul_b = MUL_W'(abs_coord(x_ff));
         end
         S_SQY: begin
            mul_a = MUL_W'(abs_coord(y_ff));
            mul_b = MUL_W'(abs_coord(y_ff));
         end
         S_SQZ: begin
            mul_a = MUL_W'(abs_coord(z_ff));
            mul_b = MUL_W'(abs_coord(z_ff));
         end
         S_SQI: begin
            mul_a = MUL_W'(incl_ff);
            mul_b = MUL_W'(incl_ff);
         end
         default: begin
            mul_a = inc2_ff;
            mul_b = d2_ff[D2PW-1 -: MUL_W];
         end
      endcase
   end

   assign mul_p = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff    <= FORWARD_RESET;
         side_ff   <= SIDE_RESET;
         spread_ff <= SPREAD_RESET;
         incl_ff   <= INCLINE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_FORWARD_CELLS: fwd_ff    <= csr_data[FORWARD_W-1:0];
            CSR_SIDE_CELLS:    side_ff   <= csr_data[SIDE_W-1:0];
            CSR_HEIGHT_SPREAD: spread_ff <= csr_data[SPREAD_W-1:0];
            CSR_INCLINE:       incl_ff   <= csr_data[INCLINE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_rsp_ff   <= 1'b0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= RSP_DW'({res_drive_ff, res_flat_ff,
                                     idx_ff[CELL_NUM_W-1:0], res_in_ff});
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  kind_raw_ff <= req_tuser;
                  kind_ff     <= kind_type'(req_tuser);
                  x_ff        <= signed'(req_tdata[C-1:0]);
                  y_ff        <= signed'(req_tdata[2*C-1:C]);
                  z_ff        <= signed'(req_tdata[3*C-1:2*C]);
                  state_ff    <= S_INDEX;
               end
            end
            S_INDEX: begin
               res_in_ff    <= 1'b0;
               res_flat_ff  <= 1'b0;
               res_drive_ff <= 1'b0;
               case (kind_ff) inside
                  KIND_ACCUM, KIND_CLASSIFY: begin
                     if (in_range_in) begin
                        idx_ff   <= idx_in;
                        state_ff <= S_READ;
                     end else begin
                        idx_ff   <= '0;
                        state_ff <= S_DONE;
                     end
                  end
                  KIND_CLEAR: begin
                     idx_ff      <= '0;
                     clr_rsp_ff  <= 1'b1;
                     clr_addr_ff <= '0;
                     state_ff    <= S_CLEAR;
                  end
                  default: begin
                     idx_ff   <= '0;
                     state_ff <= S_DONE;
                  end
               endcase
            end
            S_READ: begin
               state_ff <= S_MODIFY;
            end
            S_MODIFY: begin
               res_in_ff <= 1'b1;
               if (kind_ff == KIND_ACCUM) begin
                  res_flat_ff <= flat_new;
                  state_ff    <= S_DONE;
               end else begin
                  res_flat_ff  <= flat_old;
                  res_drive_ff <= flat_old;
                  if (flat_old && (z_ff > 0)) begin
                     state_ff <= S_SQX;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_SQX: begin
               sqx_ff   <= mul_p[2*C-1:0];
               state_ff <= S_SQY;
            end
            S_SQY: begin
               sqy_ff   <= mul_p[2*C-1:0];
               state_ff <= S_SQZ;
            end
            S_SQZ: begin
               sqz_ff   <= mul_p[2*C-1:0];
               state_ff <= S_SQI;
            end
            S_SQI: begin
               inc2_ff  <= mul_p[MUL_W-1:0];
               state_ff <= S_SUM;
            end
            S_SUM: begin
               d2_ff    <= D2PW'(sqx_ff) + D2PW'(sqy_ff);
               acc_ff   <= '0;
               ch_ff    <= CHW'(NCH);
               state_ff <= S_PROD;
            end
            S_PROD: begin
               prod_ff  <= mul_p;
               state_ff <= S_ACC;
            end
            S_ACC: begin
               acc_ff <= (acc_ff << MUL_W) + PW'(prod_ff);
               d2_ff  <= d2_ff << MUL_W;
               ch_ff  <= ch_ff - CHW'(1);
               if (ch_ff == CHW'(1)) begin
                  state_ff <= S_CMP;
               end else begin
                  state_ff <= S_PROD;
               end
            end
            S_CMP: begin
               res_drive_ff <= ((PW'(sqz_ff) << FRAC_SHIFT) <= acc_ff);
               state_ff     <= S_DONE;
            end
            S_DONE: begin
               if (rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            S_CLEAR: begin
               if (clr_addr_ff == LAST_ADDR) begin
                  clr_rsp_ff <= 1'b0;
                  state_ff   <= clr_rsp_ff ? S_DONE : S_IDLE;
               end else begin
                  clr_addr_ff <= clr_addr_ff + AW'(1);
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
